[rtl/core/imp_pkg.sv]
// Package: item types, finaliser state encoding and fixed constants for the PSNR/MAE meter.
package imp_pkg;

    typedef struct packed {
        logic [7:0] ref_pixel;
        logic [7:0] test_pixel;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [22:0] psnr_db;
        logic [23:0] mae;
        logic [39:0] sq_err_sum;
        logic [31:0] abs_err_sum;
        logic [24:0] pixels;
        logic        identical;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_NORM,
        ST_SQR,
        ST_DLT,
        ST_PMUL,
        ST_PRND,
        ST_DIV,
        ST_OUT
    } back_state_t;

    localparam logic [15:0] PEAK_SQ        = 16'd65025;
    localparam logic [25:0] TEN_LOG10_TWO  = 26'd50504453;
    localparam logic [22:0] PSNR_MAX       = 23'd8388607;
    localparam int          LOG_FRAC_BITS  = 24;

endpackage

[rtl/core/imp_front.sv]
// Front end: per-item error accumulation, snapshot of the sums on the last item.
module imp_front #(
    parameter int MAX_PIXELS_LOG2 = 24,
    parameter int CW = MAX_PIXELS_LOG2 + 1,
    parameter int AW = MAX_PIXELS_LOG2 + 8,
    parameter int SW = MAX_PIXELS_LOG2 + 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  imp_pkg::in_t      s_item,
    input  logic              q_full,
    output logic              q_push,
    output logic [SW+AW+CW-1:0] q_data
);

    logic [SW-1:0] sq_reg, sq_next;
    logic [AW-1:0] abs_reg, abs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    diff;
    logic [15:0]   diff_sq;
    logic          acc;
    logic          take;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign diff    = (s_item.ref_pixel > s_item.test_pixel) ?
                     (s_item.ref_pixel - s_item.test_pixel) :
                     (s_item.test_pixel - s_item.ref_pixel);
    assign diff_sq = 16'(diff) * 16'(diff);
    assign acc     = !cnt_reg[CW-1];

    always_comb begin
        sq_next  = sq_reg;
        abs_next = abs_reg;
        cnt_next = cnt_reg;
        if (acc) begin
            sq_next  = sq_reg + SW'(diff_sq);
            abs_next = abs_reg + AW'(diff);
            cnt_next = cnt_reg + CW'(1);
        end
    end

    assign q_push = take && s_item.last;
    assign q_data = {sq_next, abs_next, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg  <= '0;
            abs_reg <= '0;
            cnt_reg <= '0;
        end else if (take) begin
            if (s_item.last) begin
                sq_reg  <= '0;
                abs_reg <= '0;
                cnt_reg <= '0;
            end else begin
                sq_reg  <= sq_next;
                abs_reg <= abs_next;
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

[rtl/core/imp_fifo.sv]
// Two-entry queue carrying image totals from the front end to the finaliser.
module imp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/core/imp_back.sv]
// Finaliser: iterative log2 for PSNR, bit-serial divider for MAE, result register.
module imp_back #(
    parameter int MAX_PIXELS_LOG2 = 24,
    parameter int CW = MAX_PIXELS_LOG2 + 1,
    parameter int AW = MAX_PIXELS_LOG2 + 8,
    parameter int SW = MAX_PIXELS_LOG2 + 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_not_empty,
    input  logic [SW+AW+CW-1:0]  q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output imp_pkg::out_t        m_item
);

    localparam int NW  = SW + 32;
    localparam int EW  = $clog2(NW);
    localparam int LW  = EW + imp_pkg::LOG_FRAC_BITS;
    localparam int PW  = LW + 26;
    localparam int NB  = AW + 16;
    localparam int NBW = $clog2(NB + 1);

    imp_pkg::back_state_t state_reg, state_next;

    logic [SW-1:0]  sq_reg;
    logic [AW-1:0]  abs_reg;
    logic [CW-1:0]  cnt_reg;
    logic           ident_reg;
    logic           second_reg;
    logic [NW-1:0]  nrm_reg;
    logic [EW-1:0]  sh_reg;
    logic [31:0]    m_reg;
    logic [23:0]    fr_reg;
    logic [4:0]     step_reg;
    logic [LW-1:0]  ln_reg;
    logic [LW-1:0]  dlt_reg;
    logic [PW-1:0]  prod_reg;
    logic [22:0]    psnr_reg;
    logic [NB-1:0]  num_reg;
    logic [NB-1:0]  quo_reg;
    logic [CW:0]    rem_reg;
    logic [NBW-1:0] bit_reg;
    logic           out_valid_reg;
    imp_pkg::out_t  out_reg;

    logic [63:0]    sqr;
    logic [32:0]    sqr_top;
    logic [LW-1:0]  log_val;
    logic [CW+1:0]  rem_try;
    logic [PW:0]    rnd;
    logic           start, done_log, out_free;

    assign sqr      = 64'(m_reg) * 64'(m_reg);
    assign sqr_top  = sqr[63:31];
    assign log_val  = {EW'(NW - 1) - sh_reg, fr_reg};
    assign rem_try  = {rem_reg, num_reg[NB-1]} - {2'b00, cnt_reg};
    assign rnd      = {1'b0, prod_reg} + (PW + 1)'(33'h080000000);
    assign out_free = !out_valid_reg || m_ready;
    assign done_log = (step_reg == 5'(imp_pkg::LOG_FRAC_BITS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            imp_pkg::ST_IDLE: if (q_not_empty) state_next = imp_pkg::ST_LOAD;
            imp_pkg::ST_LOAD: state_next = (sq_reg == '0) ? imp_pkg::ST_DIV : imp_pkg::ST_NORM;
            imp_pkg::ST_NORM: if (nrm_reg[NW-1]) state_next = imp_pkg::ST_SQR;
            imp_pkg::ST_SQR: begin
                if (done_log) begin
                    state_next = second_reg ? imp_pkg::ST_DLT : imp_pkg::ST_NORM;
                end
            end
            imp_pkg::ST_DLT:  state_next = imp_pkg::ST_PMUL;
            imp_pkg::ST_PMUL: state_next = imp_pkg::ST_PRND;
            imp_pkg::ST_PRND: state_next = imp_pkg::ST_DIV;
            imp_pkg::ST_DIV:  if (bit_reg == NBW'(NB - 1)) state_next = imp_pkg::ST_OUT;
            imp_pkg::ST_OUT:  if (out_free) state_next = imp_pkg::ST_IDLE;
            default:          state_next = imp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        start = (state_reg == imp_pkg::ST_IDLE) && q_not_empty;
        q_pop = start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= imp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == imp_pkg::ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            imp_pkg::ST_IDLE: begin
                sq_reg  <= q_head[SW+AW+CW-1 -: SW];
                abs_reg <= q_head[AW+CW-1 -: AW];
                cnt_reg <= q_head[CW-1:0];
            end
            imp_pkg::ST_LOAD: begin
                ident_reg  <= (sq_reg == '0);
                second_reg <= 1'b0;
                nrm_reg    <= NW'(cnt_reg) * NW'(imp_pkg::PEAK_SQ);
                sh_reg     <= '0;
                psnr_reg   <= imp_pkg::PSNR_MAX;
                num_reg    <= {abs_reg, 16'h0000} + NB'(cnt_reg >> 1);
                quo_reg    <= '0;
                rem_reg    <= '0;
                bit_reg    <= '0;
            end
            imp_pkg::ST_NORM: begin
                if (nrm_reg[NW-1]) begin
                    m_reg    <= nrm_reg[NW-1 -: 32];
                    fr_reg   <= '0;
                    step_reg <= '0;
                end else begin
                    nrm_reg <= {nrm_reg[NW-2:0], 1'b0};
                    sh_reg  <= sh_reg + EW'(1);
                end
            end
            imp_pkg::ST_SQR: begin
                step_reg <= step_reg + 5'd1;
                if (sqr_top[32]) begin
                    m_reg  <= sqr_top[32:1];
                    fr_reg <= {fr_reg[22:0], 1'b1};
                end else begin
                    m_reg  <= sqr_top[31:0];
                    fr_reg <= {fr_reg[22:0], 1'b0};
                end
                if (done_log && !second_reg) begin
                    ln_reg     <= {EW'(NW - 1) - sh_reg,
                                   fr_reg[22:0], sqr_top[32]};
                    second_reg <= 1'b1;
                    nrm_reg    <= NW'(sq_reg);
                    sh_reg     <= '0;
                end
            end
            imp_pkg::ST_DLT:  dlt_reg <= (ln_reg > log_val) ? (ln_reg - log_val) : '0;
            imp_pkg::ST_PMUL: prod_reg <= PW'(dlt_reg) * PW'(imp_pkg::TEN_LOG10_TWO);
            imp_pkg::ST_PRND: begin
                if (rnd[PW:32] > (PW - 31)'(imp_pkg::PSNR_MAX)) begin
                    psnr_reg <= imp_pkg::PSNR_MAX;
                end else begin
                    psnr_reg <= rnd[54:32];
                end
            end
            imp_pkg::ST_DIV: begin
                bit_reg <= bit_reg + NBW'(1);
                num_reg <= {num_reg[NB-2:0], 1'b0};
                if (!rem_try[CW+1]) begin
                    rem_reg <= rem_try[CW:0];
                    quo_reg <= {quo_reg[NB-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[CW-1:0], num_reg[NB-1]};
                    quo_reg <= {quo_reg[NB-2:0], 1'b0};
                end
            end
            imp_pkg::ST_OUT: begin
                if (out_free) begin
                    out_reg.psnr_db     <= psnr_reg;
                    out_reg.mae         <= 24'(quo_reg);
                    out_reg.sq_err_sum  <= 40'(sq_reg);
                    out_reg.abs_err_sum <= 32'(abs_reg);
                    out_reg.pixels      <= 25'(cnt_reg);
                    out_reg.identical   <= ident_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

[rtl/core/image_psnr_mae_metric_unit.sv]
// Top level of the PSNR and mean absolute error meter for 8-bit image pairs.
//  channel | direction | ports                     | item
//  s_      | in        | s_valid s_ready s_item    | reference/test pixel pair, last flag
//  m_      | out       | m_valid m_ready m_item    | PSNR, MAE, sums, count, identical flag
// Pixel pairs are accumulated at one item per cycle; s_ready drops only while
// the two-entry totals queue is full. Each image is finalised in normalise
// shifts (up to 2*MAX_PIXELS_LOG2+79), 24 squaring steps per log2 and a
// division at one quotient bit per cycle, plus any wait on m_ready,
// overlapping the next image. Reset is synchronous, active low, and clears
// sums, queue and the result valid flag.
module image_psnr_mae_metric_unit #(
    parameter int MAX_PIXELS_LOG2 = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  imp_pkg::in_t  s_item,
    output logic          m_valid,
    input  logic          m_ready,
    output imp_pkg::out_t m_item
);

    localparam int CW = MAX_PIXELS_LOG2 + 1;
    localparam int AW = MAX_PIXELS_LOG2 + 8;
    localparam int SW = MAX_PIXELS_LOG2 + 16;
    localparam int TW = SW + AW + CW;

    logic          q_full, q_push, q_pop, q_not_empty;
    logic [TW-1:0] q_data, q_head;

    imp_front #(
        .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2), .CW(CW), .AW(AW), .SW(SW)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .q_full(q_full), .q_push(q_push), .q_data(q_data)
    );

    imp_fifo #(.WIDTH(TW)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(q_data), .pop(q_pop),
        .full(q_full), .not_empty(q_not_empty), .head(q_head)
    );

    imp_back #(
        .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2), .CW(CW), .AW(AW), .SW(SW)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_not_empty(q_not_empty), .q_head(q_head), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

endmodule

[test/image_psnr_mae_metric_checker.sv]
// Checker for the PSNR/MAE meter: watches both channels, predicts results, compares them.
module image_psnr_mae_metric_checker #(
    parameter int MAX_PIXELS_LOG2 = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  imp_pkg::in_t  s_item,
    input  logic          m_valid,
    input  logic          m_ready,
    input  imp_pkg::out_t m_item,
    output int            errors,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [39:0]   sq_sum;
    logic [31:0]   abs_sum;
    logic [24:0]   pair_cnt;
    imp_pkg::out_t metrics_q[$];

    // log2 in Q.24 by repeated squaring of the normalised mantissa
    function automatic longint unsigned log2_fix(longint unsigned v);
        int unsigned     e;
        longint unsigned m;
        longint unsigned frac;
        e = 0;
        frac = 0;
        if (v == 0)
            return 0;
        while (e < 63 && (v >> (e + 1)) != 0)
            e++;
        m = (e > 31) ? (v >> (e - 31)) : (v << (31 - e));
        for (int k = 0; k < imp_pkg::LOG_FRAC_BITS; k++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac |= 1;
                m = m >> 1;
            end
        end
        return (longint'(e) << imp_pkg::LOG_FRAC_BITS) | frac;
    endfunction

    function automatic imp_pkg::out_t image_metrics(logic [39:0] sq, logic [31:0] ab,
                                                    logic [24:0] n);
        imp_pkg::out_t   r;
        longint unsigned ln;
        longint unsigned ld;
        longint unsigned dlt;
        longint unsigned p;
        r.identical = (sq == 0);
        if (r.identical) begin
            p = imp_pkg::PSNR_MAX;
        end else begin
            ln = log2_fix(longint'(imp_pkg::PEAK_SQ) * n);
            ld = log2_fix(sq);
            dlt = (ln > ld) ? ln - ld : 0;
            p = (dlt * longint'(imp_pkg::TEN_LOG10_TWO) + 64'h8000_0000) >> 32;
            if (p > imp_pkg::PSNR_MAX)
                p = imp_pkg::PSNR_MAX;
        end
        r.psnr_db = p[22:0];
        r.mae = 24'(((longint'(ab) << 16) + (n >> 1)) / n);
        r.sq_err_sum = sq;
        r.abs_err_sum = ab;
        r.pixels = n;
        return r;
    endfunction

    function automatic int field_bad(string name, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
            return 1;
        end
        return 0;
    endfunction

    assign pending = metrics_q.size();

    always @(posedge aclk) begin
        logic [7:0]    d;
        logic [39:0]   sq_n;
        logic [31:0]   abs_n;
        logic [24:0]   cnt_n;
        imp_pkg::out_t e;
        int            bad;
        if (!aresetn) begin
            sq_sum <= '0;
            abs_sum <= '0;
            pair_cnt <= '0;
            errors <= 0;
            metrics_q.delete();
        end else begin
            bad = 0;
            if (s_valid && s_ready) begin
                d = (s_item.ref_pixel > s_item.test_pixel) ?
                    s_item.ref_pixel - s_item.test_pixel : s_item.test_pixel - s_item.ref_pixel;
                sq_n = sq_sum;
                abs_n = abs_sum;
                cnt_n = pair_cnt;
                if (pair_cnt < (25'd1 << MAX_PIXELS_LOG2)) begin
                    sq_n = sq_n + d * d;
                    abs_n = abs_n + d;
                    cnt_n = cnt_n + 1;
                end
                if (s_item.last) begin
                    metrics_q.push_back(image_metrics(sq_n, abs_n, cnt_n));
                    sq_n = '0;
                    abs_n = '0;
                    cnt_n = '0;
                end
                sq_sum <= sq_n;
                abs_sum <= abs_n;
                pair_cnt <= cnt_n;
            end
            if (m_valid && m_ready) begin
                if (metrics_q.size() == 0) begin
                    $display("%0t: result with none expected, got %p", $time, m_item);
                    bad = 1;
                end else begin
                    e = metrics_q.pop_front();
                    bad += field_bad("psnr_db", e.psnr_db, m_item.psnr_db);
                    bad += field_bad("mae", e.mae, m_item.mae);
                    bad += field_bad("sq_err_sum", e.sq_err_sum, m_item.sq_err_sum);
                    bad += field_bad("abs_err_sum", e.abs_err_sum, m_item.abs_err_sum);
                    bad += field_bad("pixels", e.pixels, m_item.pixels);
                    bad += field_bad("identical", e.identical, m_item.identical);
                end
            end
            errors <= errors + bad;
        end
    end
endmodule

[test/testbench.sv]
// Testbench top for the PSNR/MAE meter: stimulus, flow control and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          s_valid = 0;
    logic          s_ready;
    imp_pkg::in_t  s_item = '0;
    logic          m_valid;
    logic          m_ready = 0;
    imp_pkg::out_t m_item;
    int            errors;
    int            pending;
    bit            hold_off = 0;
    bit            no_gaps = 0;
    int            cycles = 0;

    always #10 aclk = ~aclk;

    image_psnr_mae_metric_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    image_psnr_mae_metric_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .errors(errors), .pending(pending)
    );

    function automatic int draw_gap();
        if (no_gaps || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    task automatic send_pair(logic [7:0] r, logic [7:0] t, logic lst);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= '{ref_pixel: r, test_pixel: t, last: lst};
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // one image of n pairs; style picks identical, near or unrelated content
    task automatic send_image(int n, int style);
        logic [7:0] r;
        logic [7:0] t;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 255);
            case (style)
                0: t = r;
                1: t = r + 8'($urandom_range(0, 6)) - 8'd3;
                default: t = $urandom_range(0, 255);
            endcase
            send_pair(r, t, i == n - 1);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // receiver
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end else begin
                stall = draw_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(negedge aclk);
            while (!m_valid) @(negedge aclk);
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int sent;
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single pairs at the extremes, identical images, maximum error
        send_pair(8'd0, 8'd0, 1'b1);
        send_pair(8'd255, 8'd255, 1'b1);
        send_pair(8'd255, 8'd0, 1'b1);
        send_pair(8'd0, 8'd255, 1'b1);
        send_pair(8'd1, 8'd0, 1'b1);
        send_pair(8'd170, 8'd85, 1'b0);
        send_pair(8'd85, 8'd170, 1'b1);
        for (int i = 0; i < 4; i++) send_pair(8'd255, 8'd0, i == 3);
        for (int i = 0; i < 3; i++) send_pair(8'(i * 100), 8'(i * 100), i == 2);
        send_pair(8'd10, 8'd11, 1'b0);
        send_pair(8'd10, 8'd10, 1'b0);
        send_pair(8'd10, 8'd10, 1'b1);
        drain();

        // receiver holds off while short images keep coming
        hold_off = 1;
        no_gaps = 1;
        for (int i = 0; i < 12; i++) send_image($urandom_range(1, 3), $urandom_range(0, 2));
        no_gaps = 0;
        drain();

        sent = 0;
        while (sent < 1200) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 25);
            if ($urandom_range(0, 9) == 0)
                no_gaps = ~no_gaps;
            send_image(n, $urandom_range(0, 3));
            sent += n;
        end
        drain();
        repeat (300) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
